### sv/bas_pkg.sv
package bas_pkg;

	localparam int unsigned SinceMax  = 1023;
	localparam int unsigned PeriodMax = 8191;

	localparam logic [9:0]  DEBOUNCE_RST = 10'd100;
	localparam logic [9:0]  REPEAT_RST   = 10'd100;
	localparam logic [9:0]  PULSE_RST    = 10'd500;
	localparam logic [12:0] LIMIT_RST    = 13'd5000;
	localparam logic [12:0] FINE_RST     = 13'd100;
	localparam logic [7:0]  COARSE_RST   = 8'd10;
	localparam logic [12:0] PERIOD_RST   = 13'd1000;

	typedef enum logic [2:0] {
		REG_DEBOUNCE = 3'd0,
		REG_REPEAT   = 3'd1,
		REG_PULSE    = 3'd2,
		REG_LIMIT    = 3'd3,
		REG_FINE     = 3'd4,
		REG_COARSE   = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_HIGH = 3'b010,
		PH_LOW  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [9:0]  debounce_ticks;
		logic [9:0]  repeat_ticks;
		logic [9:0]  pulse_ticks;
		logic [12:0] period_limit;
		logic [12:0] fine_threshold;
		logic [7:0]  coarse_step;
	} cfg_t;

	typedef struct packed {
		logic        wave_out;
		logic [12:0] period_ms;
		logic        manual_mode;
	} result_t;

	// One period step: shorten (coarse above the fine threshold, else by one) or lengthen.
	function automatic logic [12:0] bas_step(input logic [12:0] period, input logic down,
	                                         input cfg_t cfg);
		logic [13:0] sum;
		logic [12:0] res;
		sum = {1'b0, period} + {6'd0, cfg.coarse_step};
		res = period;
		if (!down) begin
			if (period > cfg.fine_threshold) begin
				res = (period > {5'd0, cfg.coarse_step}) ?
				      (period - {5'd0, cfg.coarse_step}) : 13'd1;
			end else if (period > 13'd1) begin
				res = period - 13'd1;
			end
		end else if (period < cfg.period_limit) begin
			res = (sum > 14'(PeriodMax)) ? 13'(PeriodMax) : sum[12:0];
		end
		return res;
	endfunction

endpackage

### sv/bas_cfg.sv
module bas_cfg (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output bas_pkg::cfg_t cfg
);
	import bas_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RST;
			cfg_q.repeat_ticks   <= REPEAT_RST;
			cfg_q.pulse_ticks    <= PULSE_RST;
			cfg_q.period_limit   <= LIMIT_RST;
			cfg_q.fine_threshold <= FINE_RST;
			cfg_q.coarse_step    <= COARSE_RST;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_DEBOUNCE: cfg_q.debounce_ticks <= pwdata[9:0];
				REG_REPEAT:   cfg_q.repeat_ticks   <= pwdata[9:0];
				REG_PULSE:    cfg_q.pulse_ticks    <= pwdata[9:0];
				REG_LIMIT:    cfg_q.period_limit   <= pwdata[12:0];
				REG_FINE:     cfg_q.fine_threshold <= pwdata[12:0];
				REG_COARSE:   cfg_q.coarse_step    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_DEBOUNCE: prdata = {22'd0, cfg_q.debounce_ticks};
			REG_REPEAT:   prdata = {22'd0, cfg_q.repeat_ticks};
			REG_PULSE:    prdata = {22'd0, cfg_q.pulse_ticks};
			REG_LIMIT:    prdata = {19'd0, cfg_q.period_limit};
			REG_FINE:     prdata = {19'd0, cfg_q.fine_threshold};
			REG_COARSE:   prdata = {24'd0, cfg_q.coarse_step};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

### sv/bas_core.sv
module bas_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [3:0]      levels,
	input  bas_pkg::cfg_t   cfg,
	output bas_pkg::result_t result
);
	import bas_pkg::*;

	logic [12:0] period_q, period_n;
	logic        mode_q, mode_n;
	logic [9:0]  since_q, since_n;
	logic [3:0]  last_q;
	logic        held_q, held_n;
	logic        hold_q, hold_n;
	logic [9:0]  rc_q, rc_n;
	logic [11:0] half_q, half_n;
	phase_t      phase_q, phase_n;
	logic [10:0] pc_q, pc_n;

	logic [3:0]  rising;
	logic [9:0]  pt, rt;
	logic        accepted, pulse_out, pulse_level, do_step, step_down, wave;
	logic [11:0] half_len;

	always_comb begin
		rising = levels & ~last_q;
		pt = (cfg.pulse_ticks == 10'd0) ? 10'd1 : cfg.pulse_ticks;
		rt = (cfg.repeat_ticks == 10'd0) ? 10'd1 : cfg.repeat_ticks;
		mode_n = mode_q;
		held_n = held_q;
		hold_n = hold_q;
		rc_n = rc_q;
		pc_n = pc_q;
		accepted = 1'b0;
		pulse_out = 1'b0;
		pulse_level = 1'b0;
		do_step = 1'b0;
		step_down = held_q;

		if (hold_q) begin
			rc_n = rc_q + 10'd1;
			if (rc_n >= rt) begin
				rc_n = 10'd0;
				if (levels[{1'b0, held_q}]) do_step = 1'b1;
				else hold_n = 1'b0;
			end
		end else if (pc_q != 11'd0) begin
			pulse_out = 1'b1;
			pulse_level = (pc_q > {1'b0, pt});
			pc_n = pc_q - 11'd1;
		end else if (rising != 4'd0 &&
		             (since_q > cfg.debounce_ticks || since_q == 10'(SinceMax))) begin
			accepted = 1'b1;
			if (rising[0]) begin
				if (period_q > 13'd1) begin
					held_n = 1'b0; hold_n = 1'b1; rc_n = 10'd0;
					do_step = 1'b1; step_down = 1'b0;
				end
			end else if (rising[1]) begin
				if (period_q < cfg.period_limit) begin
					held_n = 1'b1; hold_n = 1'b1; rc_n = 10'd0;
					do_step = 1'b1; step_down = 1'b1;
				end
			end else if (rising[2]) begin
				mode_n = ~mode_q;
			end else if (mode_q) begin
				pc_n = {pt, 1'b0} - 11'd1;
				pulse_out = 1'b1;
				pulse_level = 1'b1;
			end
		end

		period_n = do_step ? bas_step(period_q, step_down, cfg) : period_q;

		if (accepted) since_n = 10'd0;
		else if (since_q != 10'(SinceMax)) since_n = since_q + 10'd1;
		else since_n = since_q;

		half_len = (period_n[12:1] == 12'd0) ? 12'd1 : period_n[12:1];
		phase_n = phase_q;
		half_n = half_q;
		wave = 1'b0;
		if (!hold_n && !pulse_out) begin
			if (phase_n != PH_HIGH && phase_n != PH_LOW) begin
				phase_n = PH_IDLE;
				if (!mode_n) begin
					phase_n = PH_HIGH;
					half_n = half_len;
				end
			end
			case (phase_n)
				PH_HIGH: begin
					wave = 1'b1;
					if (half_n != 12'd0) half_n = half_n - 12'd1;
					if (half_n == 12'd0) begin
						phase_n = PH_LOW;
						half_n = half_len;
					end
				end
				PH_LOW: begin
					if (half_n != 12'd0) half_n = half_n - 12'd1;
					if (half_n == 12'd0) phase_n = PH_IDLE;
				end
				default: wave = 1'b0;
			endcase
		end else begin
			wave = (phase_q == PH_HIGH);
		end

		result.wave_out    = pulse_out ? pulse_level : wave;
		result.period_ms   = period_n;
		result.manual_mode = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			mode_q   <= 1'b0;
			since_q  <= 10'(SinceMax);
			last_q   <= 4'd0;
			held_q   <= 1'b0;
			hold_q   <= 1'b0;
			rc_q     <= 10'd0;
			half_q   <= 12'd0;
			phase_q  <= PH_IDLE;
			pc_q     <= 11'd0;
		end else if (advance) begin
			period_q <= period_n;
			mode_q   <= mode_n;
			since_q  <= since_n;
			last_q   <= levels;
			held_q   <= held_n;
			hold_q   <= hold_n;
			rc_q     <= rc_n;
			half_q   <= half_n;
			phase_q  <= phase_n;
			pc_q     <= pc_n;
		end
	end

endmodule

### sv/button_adjusted_square_wave.sv
// Channel    Dir  Handshake          Payload
// s_axis     in   s_tvalid/s_tready  one tick: four button levels
// m_axis     out  m_tvalid/m_tready  one result per tick: wave, period, mode
// apb        in   psel/penable       six timing and step registers at 4*i
//
// A new tick transaction can enter every cycle, except while a result waits unclaimed.
// Its result is captured in the output register when the tick is accepted.
// The output register parts the two sides: a tick is taken while the held result
// is being taken in the same cycle, and input stalls only while the result waits.
// arst_n clears state to period 1000, auto mode, wave idle low, no hold or pulse.
module button_adjusted_square_wave (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: [0] up_button, [1] down_button, [2] mode_button, [3] pulse_button
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// m_tdata: [0] wave_out, [13:1] period_ms, [14] manual_mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bas_pkg::*;

	cfg_t    cfg;
	result_t result;
	logic    advance;
	logic    out_valid_q;
	logic [15:0] out_data_q;

	// Take a tick whenever the output slot is free or being emptied now.
	assign s_tready = !out_valid_q || m_tready;
	assign advance  = s_tvalid && s_tready;

	bas_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bas_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.levels  (s_tdata[3:0]),
		.cfg     (cfg),
		.result  (result)
	);

	// Hold the result until taken; load a fresh one with every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {1'b0, result.manual_mode, result.period_ms, result.wave_out};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### sv/bas_checker.sv
module bas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// Hold a stalled result.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Every accepted tick yields a result next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted tick gave no result");

	// Drop no result: no tick is taken while one waits unclaimed.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken over a waiting result");

	// Period never reaches zero.
	a_period: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[13:1] != 13'd0)
		else $error("period is zero");

endmodule

bind button_adjusted_square_wave bas_checker u_bas_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bas_pkg::*;

	// Abort after this many cycles in a row with no transaction on any port.
	localparam int unsigned IdleLimit   = 2000;
	// Extra cycles to let pass once every expected output has arrived.
	localparam int unsigned DrainCycles = 5;
	// Print at most this many mismatch lines; count every one of them.
	localparam int unsigned ShowLimit   = 50;

	localparam logic [3:0] BTN_NONE  = 4'b0000;
	localparam logic [3:0] BTN_UP    = 4'b0001;
	localparam logic [3:0] BTN_DOWN  = 4'b0010;
	localparam logic [3:0] BTN_MODE  = 4'b0100;
	localparam logic [3:0] BTN_PULSE = 4'b1000;
	localparam logic [3:0] BTN_ALL   = 4'b1111;

	// Tracks the generator state tick by tick and holds the outputs still to come.
	class wave_tracker;
		cfg_t        cfg;
		logic [12:0] period;
		logic        manual;
		logic [9:0]  since_edge;
		logic [3:0]  last_levels;
		logic        lengthen;
		logic        holding;
		logic [9:0]  repeat_cnt;
		logic [12:0] half_cnt;
		phase_t      phase;
		logic [10:0] pulse_cnt;
		result_t     pending[$];
		int unsigned errors;
		int unsigned seen;

		function new();
			cfg = '{debounce_ticks: DEBOUNCE_RST, repeat_ticks: REPEAT_RST,
			        pulse_ticks: PULSE_RST, period_limit: LIMIT_RST,
			        fine_threshold: FINE_RST, coarse_step: COARSE_RST};
			period      = PERIOD_RST;
			manual      = 1'b0;
			since_edge  = 10'(SinceMax);
			last_levels = '0;
			lengthen    = 1'b0;
			holding     = 1'b0;
			repeat_cnt  = '0;
			half_cnt    = '0;
			phase       = PH_IDLE;
			pulse_cnt   = '0;
			errors      = 0;
			seen        = 0;
		endfunction

		function void set_cfg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_DEBOUNCE: cfg.debounce_ticks = v[9:0];
				REG_REPEAT:   cfg.repeat_ticks   = v[9:0];
				REG_PULSE:    cfg.pulse_ticks    = v[9:0];
				REG_LIMIT:    cfg.period_limit   = v[12:0];
				REG_FINE:     cfg.fine_threshold = v[12:0];
				REG_COARSE:   cfg.coarse_step    = v[7:0];
				default: ;
			endcase
		endfunction

		function void adjust_period();
			logic [13:0] sum;
			sum = {1'b0, period} + 14'(cfg.coarse_step);
			if (!lengthen) begin
				if (period > cfg.fine_threshold)
					period = (period > 13'(cfg.coarse_step)) ?
					         period - 13'(cfg.coarse_step) : 13'd1;
				else if (period > 13'd1)
					period = period - 13'd1;
			end else if (period < cfg.period_limit) begin
				period = (sum > 14'(PeriodMax)) ? 13'(PeriodMax) : sum[12:0];
			end
		endfunction

		function logic [12:0] half_len();
			logic [12:0] h;
			h = period >> 1;
			return (h == 13'd0) ? 13'd1 : h;
		endfunction

		function void note_tick(logic [3:0] lv);
			logic [3:0] rising;
			logic [9:0] pt;
			logic [9:0] rt;
			logic       accepted;
			logic       pulse_out;
			logic       pulse_lvl;
			logic       wave;
			result_t    r;
			rising      = lv & ~last_levels;
			pt          = (cfg.pulse_ticks == '0) ? 10'd1 : cfg.pulse_ticks;
			rt          = (cfg.repeat_ticks == '0) ? 10'd1 : cfg.repeat_ticks;
			accepted    = 1'b0;
			pulse_out   = 1'b0;
			pulse_lvl   = 1'b0;
			wave        = 1'b0;
			last_levels = lv;

			if (holding) begin
				repeat_cnt = repeat_cnt + 10'd1;
				if (repeat_cnt >= rt) begin
					repeat_cnt = '0;
					if (lv[{1'b0, lengthen}])
						adjust_period();
					else
						holding = 1'b0;
				end
			end else if (pulse_cnt != '0) begin
				pulse_out = 1'b1;
				pulse_lvl = (pulse_cnt > 11'(pt));
				pulse_cnt = pulse_cnt - 11'd1;
			end else if (rising != '0 &&
			             (since_edge > cfg.debounce_ticks || since_edge == 10'(SinceMax))) begin
				accepted = 1'b1;
				if (rising[0]) begin
					if (period > 13'd1) begin
						lengthen = 1'b0; holding = 1'b1; repeat_cnt = '0;
						adjust_period();
					end
				end else if (rising[1]) begin
					if (period < cfg.period_limit) begin
						lengthen = 1'b1; holding = 1'b1; repeat_cnt = '0;
						adjust_period();
					end
				end else if (rising[2]) begin
					manual = ~manual;
				end else if (manual) begin
					pulse_cnt = 11'({pt, 1'b0}) - 11'd1;
					pulse_out = 1'b1;
					pulse_lvl = 1'b1;
				end
			end

			if (accepted)
				since_edge = '0;
			else if (since_edge < 10'(SinceMax))
				since_edge = since_edge + 10'd1;

			if (!holding && !pulse_out) begin
				if (phase != PH_HIGH && phase != PH_LOW) begin
					phase = PH_IDLE;
					if (!manual) begin
						phase    = PH_HIGH;
						half_cnt = half_len();
					end
				end
				if (phase == PH_HIGH) begin
					wave = 1'b1;
					if (half_cnt != '0) half_cnt = half_cnt - 13'd1;
					if (half_cnt == '0) begin
						phase    = PH_LOW;
						half_cnt = half_len();
					end
				end else if (phase == PH_LOW) begin
					wave = 1'b0;
					if (half_cnt != '0) half_cnt = half_cnt - 13'd1;
					if (half_cnt == '0) phase = PH_IDLE;
				end
			end else begin
				wave = (phase == PH_HIGH);
			end

			r.wave_out    = pulse_out ? pulse_lvl : wave;
			r.period_ms   = period;
			r.manual_mode = manual;
			pending.push_back(r);
		endfunction

		task report(string what, int unsigned got, int unsigned want);
			errors++;
			if (errors <= ShowLimit)
				$display("mismatch at output %0d: %s got %0d want %0d", seen, what, got, want);
		endtask

		task check_output(logic [15:0] d);
			result_t w;
			seen++;
			if (pending.size() == 0) begin
				report("output with no tick pending", d, 0);
				return;
			end
			w = pending.pop_front();
			if (d[0] !== w.wave_out)       report("wave_out", d[0], w.wave_out);
			if (d[13:1] !== w.period_ms)   report("period_ms", d[13:1], w.period_ms);
			if (d[14] !== w.manual_mode)   report("manual_mode", d[14], w.manual_mode);
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// s_tdata: [0] up_button, [1] down_button, [2] mode_button, [3] pulse_button
	logic [7:0]  s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// m_tdata: [0] wave_out, [13:1] period_ms, [14] manual_mode
	logic [15:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	wave_tracker board = new();
	int unsigned idle_cycles = 0;
	int unsigned stall_len;

	button_adjusted_square_wave i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one tick after a random gap and hold it until the block takes it.
	// Sample tready right after the edge: that is the value the block saw.
	task automatic send_tick(logic [3:0] lv);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, lv};
		do @(posedge clk); while (!s_tready);
		board.note_tick(lv);
	endtask

	// Setup cycle, then access cycle; the register lands on the edge with penable high.
	// Now and then put junk above the field to show it gets dropped.
	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		logic [31:0] junk;
		junk = '0;
		if ($urandom_range(0, 3) == 0) begin
			case (idx)
				REG_LIMIT, REG_FINE: junk = $urandom() & ~32'h1fff;
				REG_COARSE:          junk = $urandom() & ~32'h00ff;
				default:             junk = $urandom() & ~32'h03ff;
			endcase
		end
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v | junk;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		board.set_cfg(idx, v);
	endtask

	// Drop valid and wait until every tick in flight has produced its output.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic load_cfg(logic [31:0] deb, logic [31:0] rpt, logic [31:0] pls,
	                        logic [31:0] lim, logic [31:0] fine, logic [31:0] crs);
		settle();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_REPEAT, rpt);
		write_reg(REG_PULSE, pls);
		write_reg(REG_LIMIT, lim);
		write_reg(REG_FINE, fine);
		write_reg(REG_COARSE, crs);
	endtask

	// Press patterns: mostly a single button held for a while, sometimes several at
	// once, sometimes chatter. The release that follows usually outlasts the
	// debounce time so the next press gets through; sometimes it is cut short.
	task automatic run_gestures(int unsigned count);
		int unsigned kind;
		int unsigned hold_len;
		int unsigned rest_len;
		int unsigned dc;
		int unsigned rc;
		logic [3:0]  lv;
		dc = (board.cfg.debounce_ticks > 10'd12) ? 12 : board.cfg.debounce_ticks;
		rc = (board.cfg.repeat_ticks > 10'd8) ? 8 : board.cfg.repeat_ticks;
		repeat (count) begin
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				repeat ($urandom_range(1, 6)) send_tick(4'($urandom()));
			end else begin
				lv = (kind < 80) ? (BTN_UP << $urandom_range(0, 3)) : 4'($urandom_range(1, 15));
				hold_len = $urandom_range(1, 2 * rc + 3);
				if ($urandom_range(0, 9) == 0) hold_len = $urandom_range(20, 40);
				repeat (hold_len) send_tick(lv);
			end
			rest_len = ($urandom_range(0, 4) != 0) ? $urandom_range(dc, dc + 4) :
			           $urandom_range(0, dc);
			repeat (rest_len) send_tick(BTN_NONE);
		end
	endtask

	// Pick a value close to the current period about half of the time so the
	// limit and threshold compares flip inside a phase.
	function automatic logic [31:0] near_period();
		int unsigned v;
		if ($urandom_range(0, 1) == 0) return $urandom_range(2, 8191);
		v = board.period + $urandom_range(0, 40);
		if (v < 2) v = 2;
		if (v > 8191) v = 8191;
		return v;
	endfunction

	// Receiver: accept in bursts, stall for random gaps in between.
	initial begin
		@(posedge arst_n);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			stall_len = pick_gap();
			if (stall_len != 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// Check every output transaction against the oldest pending expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_output(m_tdata);
	end

	// Watchdog: count cycles with no transaction on any port.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] deb;
		logic [31:0] rpt;
		logic [31:0] pls;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Slowest timing, narrowest step, lowest limit, highest threshold.
		// The debounce counter still sits saturated from reset, which is the only
		// way a press gets through here; the presses after it are lost.
		load_cfg(1023, 1023, 1023, 2, 8191, 1);
		send_tick(BTN_NONE);
		send_tick(BTN_MODE);
		send_tick(BTN_NONE);
		send_tick(BTN_MODE);
		repeat (3) send_tick(BTN_NONE);
		send_tick(BTN_UP);
		send_tick(BTN_NONE);

		// Reset values again: wait out the debounce time, then with all buttons
		// down the up button wins.
		load_cfg(32'(DEBOUNCE_RST), 32'(REPEAT_RST), 32'(PULSE_RST),
		         32'(LIMIT_RST), 32'(FINE_RST), 32'(COARSE_RST));
		repeat (100) send_tick(BTN_NONE);
		send_tick(BTN_ALL);
		send_tick(BTN_NONE);

		// Fastest timing, widest step, highest limit, lowest threshold.
		load_cfg(0, 1, 1, 8191, 1, 255);
		send_tick(BTN_NONE);
		send_tick(BTN_DOWN);
		send_tick(BTN_DOWN);
		send_tick(BTN_NONE);
		send_tick(BTN_NONE);
		send_tick(BTN_MODE);
		send_tick(BTN_NONE);
		send_tick(BTN_PULSE);
		send_tick(BTN_NONE);
		send_tick(BTN_NONE);
		send_tick(BTN_UP);
		send_tick(BTN_UP);
		send_tick(BTN_NONE);
		send_tick(BTN_NONE);
		// Down and mode together: down wins, the mode edge is lost.
		send_tick(BTN_DOWN | BTN_MODE);
		send_tick(BTN_NONE);
		send_tick(BTN_NONE);
		send_tick(BTN_MODE);
		send_tick(BTN_NONE);
		send_tick(BTN_ALL);
		send_tick(BTN_NONE);

		run_gestures(20);
		// Ramp the period into the top clamp, then walk it back down to one.
		repeat (40) send_tick(BTN_DOWN);
		repeat (3) send_tick(BTN_NONE);
		repeat (40) send_tick(BTN_UP);
		send_tick(BTN_NONE);

		// Random moderate settings with short timing so holds and pulses repeat often.
		repeat (5) begin
			deb = $urandom_range(0, 12);
			rpt = $urandom_range(1, 6);
			pls = $urandom_range(1, 6);
			load_cfg(deb, rpt, pls, near_period(), near_period(), $urandom_range(1, 255));
			run_gestures(12);
		end

		settle();
		repeat (DrainCycles) @(posedge clk);
		if (board.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
